// File: sv/matinv_pkg.sv
// Package: widths, types and constants shared by the 3x3 matrix inverse pipeline.
package matinv_pkg;

  // Input field width and the significant element width inside it
  localparam int FIELD_BITS   = 16;
  localparam int ELEMENT_BITS = 16;
  localparam int N_ELEM       = 9;

  // Derived datapath widths
  localparam int PW  = 2 * ELEMENT_BITS;     // 2x2 minor product
  localparam int CW  = PW + 1;               // cofactor
  localparam int DPW = ELEMENT_BITS + CW;    // element * cofactor
  localparam int DW  = DPW + 2;              // determinant
  localparam int FRAC_SHIFT = 24;            // Q16.16 cofactor over Q24.24 determinant -> Q16.16 result
  localparam int NW  = CW + FRAC_SHIFT;      // shifted numerator magnitude
  localparam int QBITS = 32;                 // quotient bits
  localparam int XW  = DW + QBITS;           // compare width of shifted divisor
  localparam int QW  = QBITS + 1;            // quotient with overflow bit
  localparam int OUT_BITS = 32;

  // Latency: five front stages, overflow stage, one stage per quotient bit, output
  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES   = QBITS + 1;
  localparam int TAIL_STAGES  = DIV_STAGES;

  localparam logic [OUT_BITS-1:0] Q16_ONE   = 32'h0001_0000;
  localparam logic [OUT_BITS-1:0] SAT_POS   = 32'h7FFF_FFFF;
  localparam logic [QW-1:0]       SAT_NEG_Q = 33'h0_8000_0000;
  localparam logic [QW-1:0]       Q_WRAP    = 33'h1_0000_0000;

  typedef logic signed [ELEMENT_BITS-1:0] elem_t;
  typedef logic signed [PW-1:0]           prod_t;
  typedef logic signed [CW-1:0]           cof_t;
  typedef logic signed [DPW-1:0]          dprod_t;
  typedef logic signed [DW-1:0]           det_t;
  typedef logic [NW-1:0]                  num_t;
  typedef logic [DW-1:0]                  den_t;
  typedef logic [XW-1:0]                  wide_t;
  typedef logic [QW-1:0]                  quo_t;

endpackage

// File: sv/matinv_cof.sv
// Two-stage cofactor unit: registered minor products, then registered cofactors.
module matinv_cof (
  input  logic                   clk,
  input  logic                   en,
  input  matinv_pkg::elem_t      a [matinv_pkg::N_ELEM],
  output matinv_pkg::cof_t       cof [matinv_pkg::N_ELEM],
  output matinv_pkg::elem_t      row0 [3]
);

  matinv_pkg::prod_t pa [matinv_pkg::N_ELEM];
  matinv_pkg::prod_t pb [matinv_pkg::N_ELEM];
  matinv_pkg::elem_t row0_d [3];

  // Minor products; cyclic index order carries the cofactor sign
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      localparam int I1 = (i + 1) % 3;
      localparam int I2 = (i + 2) % 3;
      localparam int J1 = (j + 1) % 3;
      localparam int J2 = (j + 2) % 3;
      always_ff @(posedge clk) begin
        if (en) begin
          pa[i*3+j]  <= matinv_pkg::prod_t'(a[I1*3+J1]) * matinv_pkg::prod_t'(a[I2*3+J2]);
          pb[i*3+j]  <= matinv_pkg::prod_t'(a[I1*3+J2]) * matinv_pkg::prod_t'(a[I2*3+J1]);
          cof[i*3+j] <= matinv_pkg::cof_t'(pa[i*3+j]) - matinv_pkg::cof_t'(pb[i*3+j]);
        end
      end
    end
  end

  // Row 0 follows along for the determinant expansion
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        row0_d[k] <= a[k];
        row0[k]   <= row0_d[k];
      end
    end
  end

endmodule

// File: sv/matinv_det.sv
// Three-stage determinant unit: products, sum, then magnitudes and signs for the divider.
module matinv_det (
  input  logic                   clk,
  input  logic                   en,
  input  matinv_pkg::cof_t       cof [matinv_pkg::N_ELEM],
  input  matinv_pkg::elem_t      row0 [3],
  output matinv_pkg::num_t       num [matinv_pkg::N_ELEM],
  output logic                   neg [matinv_pkg::N_ELEM],
  output matinv_pkg::den_t       den,
  output logic                   sing
);

  matinv_pkg::dprod_t dp [3];
  matinv_pkg::cof_t   cof3 [matinv_pkg::N_ELEM];
  matinv_pkg::cof_t   cof4 [matinv_pkg::N_ELEM];
  matinv_pkg::det_t   det;

  // Expansion along row 0, then the sum
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        dp[c] <= matinv_pkg::dprod_t'(row0[c]) * matinv_pkg::dprod_t'(cof[c]);
      end
      det <= matinv_pkg::det_t'(dp[0]) + matinv_pkg::det_t'(dp[1])
           + matinv_pkg::det_t'(dp[2]);
      cof3 <= cof;
      cof4 <= cof3;
    end
  end

  // Magnitudes, transposed cofactors for the adjugate, quotient signs
  always_ff @(posedge clk) begin
    if (en) begin
      den  <= det[matinv_pkg::DW-1] ? matinv_pkg::den_t'(-det) : matinv_pkg::den_t'(det);
      sing <= (det == '0);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          num[r*3+c] <= {(cof4[c*3+r][matinv_pkg::CW-1] ?
                          matinv_pkg::CW'(-cof4[c*3+r]) : matinv_pkg::CW'(cof4[c*3+r])),
                         matinv_pkg::FRAC_SHIFT'(0)};
          neg[r*3+c] <= cof4[c*3+r][matinv_pkg::CW-1] ^ det[matinv_pkg::DW-1];
        end
      end
    end
  end

endmodule

// File: sv/matinv_div.sv
// Pipelined restoring divider lane: overflow stage, then one quotient bit per stage.
module matinv_div (
  input  logic                   clk,
  input  logic                   en,
  input  matinv_pkg::num_t       num,
  input  matinv_pkg::den_t       den,
  input  logic                   neg_in,
  output matinv_pkg::quo_t       quo,
  output logic                   neg_out
);

  localparam int NS = matinv_pkg::QBITS;

  matinv_pkg::num_t rem [NS+1];
  matinv_pkg::den_t d   [NS+1];
  logic [NS-1:0]    q   [NS+1];
  logic             ovf [NS+1];
  logic             sg  [NS+1];

  // Quotient would not fit in 32 bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      d[0]   <= den;
      q[0]   <= '0;
      sg[0]  <= neg_in;
      ovf[0] <= matinv_pkg::wide_t'(num) >=
                (matinv_pkg::wide_t'(den) << matinv_pkg::QBITS);
    end
  end

  // Bit stages, most significant first
  for (genvar k = 1; k <= NS; k++) begin : g_bit
    localparam int B = NS - k;
    matinv_pkg::wide_t ds;
    logic              take;
    assign ds   = matinv_pkg::wide_t'(d[k-1]) << B;
    assign take = !ovf[k-1] && (matinv_pkg::wide_t'(rem[k-1]) >= ds);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? matinv_pkg::NW'(matinv_pkg::wide_t'(rem[k-1]) - ds) : rem[k-1];
        q[k]   <= q[k-1] | (NS'(take) << B);
        d[k]   <= d[k-1];
        ovf[k] <= ovf[k-1];
        sg[k]  <= sg[k-1];
      end
    end
  end

  assign quo     = ovf[NS] ? matinv_pkg::Q_WRAP : {1'b0, q[NS]};
  assign neg_out = sg[NS];

endmodule

// File: sv/matrix_inverse_3x3.sv
// Top level: 3x3 matrix inverse by adjugate, Q8.8 in, Q16.16 out, streaming.
// Pipeline order: cofactors, determinant and magnitudes, divider with one quotient bit
// per stage, output register.
// Throughput: one matrix per cycle; the whole pipeline holds while a result waits.
// Reset: rst clears the valid bits only; datapath registers are not reset.
module matrix_inverse_3x3 (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [143:0]  s_tdata,   // e_r0_c0, e_r0_c1, ... e_r2_c2, 16 bits each
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [287:0]  m_tdata,   // inv_r0_c0, inv_r0_c1, ... inv_r2_c2, 32 bits each
  output logic          m_tuser    // singular
);

  localparam int NV = matinv_pkg::FRONT_STAGES + matinv_pkg::DIV_STAGES;

  logic                  en;
  logic [NV-1:0]         vld;
  logic [matinv_pkg::TAIL_STAGES-1:0] sing_d;
  matinv_pkg::elem_t     a    [matinv_pkg::N_ELEM];
  matinv_pkg::cof_t      cof  [matinv_pkg::N_ELEM];
  matinv_pkg::elem_t     row0 [3];
  matinv_pkg::num_t      num  [matinv_pkg::N_ELEM];
  logic                  neg  [matinv_pkg::N_ELEM];
  matinv_pkg::den_t      den;
  logic                  sing;
  matinv_pkg::quo_t      quo  [matinv_pkg::N_ELEM];
  logic                  qneg [matinv_pkg::N_ELEM];
  logic [matinv_pkg::OUT_BITS-1:0] res [matinv_pkg::N_ELEM];

  // Global advance: move unless a finished result is still held
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Element unpack, low ELEMENT_BITS of each field
  always_comb begin
    for (int k = 0; k < matinv_pkg::N_ELEM; k++) begin
      a[k] = matinv_pkg::elem_t'(s_tdata[k*matinv_pkg::FIELD_BITS +: matinv_pkg::ELEMENT_BITS]);
    end
  end

  matinv_cof u_cof (.clk(clk), .en(en), .a(a), .cof(cof), .row0(row0));

  matinv_det u_det (.clk(clk), .en(en), .cof(cof), .row0(row0),
                    .num(num), .neg(neg), .den(den), .sing(sing));

  for (genvar k = 0; k < matinv_pkg::N_ELEM; k++) begin : g_lane
    matinv_div u_div (.clk(clk), .en(en), .num(num[k]), .den(den), .neg_in(neg[k]),
                      .quo(quo[k]), .neg_out(qneg[k]));

    // Sign and saturation
    always_comb begin
      if (qneg[k]) begin
        res[k] = matinv_pkg::OUT_BITS'(matinv_pkg::Q_WRAP -
                 ((quo[k] > matinv_pkg::SAT_NEG_Q) ? matinv_pkg::SAT_NEG_Q : quo[k]));
      end else begin
        res[k] = (quo[k] > matinv_pkg::QW'(matinv_pkg::SAT_POS)) ?
                 matinv_pkg::SAT_POS : quo[k][matinv_pkg::OUT_BITS-1:0];
      end
    end
  end

  // Valid bits and singular flag travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[NV-2:0], s_tvalid};
      m_tvalid <= vld[NV-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sing_d <= {sing_d[matinv_pkg::TAIL_STAGES-2:0], sing};
    end
  end

  // Output register; singular matrices give the identity
  always_ff @(posedge clk) begin
    if (en) begin
      m_tuser <= sing_d[matinv_pkg::TAIL_STAGES-1];
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          m_tdata[(r*3+c)*matinv_pkg::OUT_BITS +: matinv_pkg::OUT_BITS] <=
            sing_d[matinv_pkg::TAIL_STAGES-1] ? ((r == c) ? matinv_pkg::Q16_ONE : '0)
                                              : res[r*3+c];
        end
      end
    end
  end

endmodule
